[design/ami_pkg.sv]
// Shared types and constants of the affine matrix inverse.
package ami_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned N_OUT         = 12;
  localparam int unsigned N_COF         = 9;
  localparam int unsigned N_ROW         = 3;
  localparam int unsigned N_COL         = 4;
  localparam int unsigned PROD_W        = 2 * DATA_W;       // 2x2 minor products
  localparam int unsigned COF_W         = 2 * DATA_W + 1;   // cofactors
  localparam int unsigned PHI_W         = COF_W - DATA_W;   // upper cofactor slice
  localparam int unsigned PP_W          = DATA_W + PHI_W;   // partial products
  localparam int unsigned FULL_W        = DATA_W + COF_W;   // element times cofactor
  localparam int unsigned SUM_W         = FULL_W + 2;       // sum of three
  localparam int unsigned MAG_W         = 3 * DATA_W;       // |det| and |t| bound
  localparam int unsigned QB_W          = DATA_W + 1;       // quotient bits kept

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [FULL_W-1:0] full_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam elem_t ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    elem_t a00; elem_t a01; elem_t a02; elem_t a03;
    elem_t a10; elem_t a11; elem_t a12; elem_t a13;
    elem_t a20; elem_t a21; elem_t a22; elem_t a23;
  } in_t;

  typedef struct packed {
    elem_t r00; elem_t r01; elem_t r02; elem_t r03;
    elem_t r10; elem_t r11; elem_t r12; elem_t r13;
    elem_t r20; elem_t r21; elem_t r22; elem_t r23;
  } out_t;

endpackage

[design/ami_if.sv]
// Valid/ready channel interfaces for matrices in and inverses out.
interface ami_in_if;
  import ami_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ami_out_if;
  import ami_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ami_cof.sv]
// Input register, 2x2 minor products and the nine cofactors of the linear part.
module ami_cof (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ami_pkg::in_t     data_i,
  output logic             valid_o,
  output ami_pkg::elem_t   a_o [ami_pkg::N_ROW][ami_pkg::N_COL],
  output ami_pkg::cof_t    cof_o [ami_pkg::N_COF]
);
  import ami_pkg::*;

  localparam int unsigned N_PROD = 2 * N_COF;
  // row/column of both factors for each product; cofactor k = prod 2k - prod 2k+1
  localparam int unsigned PIDX [N_PROD][4] = '{
    '{1,1,2,2}, '{1,2,2,1},
    '{0,2,2,1}, '{0,1,2,2},
    '{0,1,1,2}, '{0,2,1,1},
    '{1,2,2,0}, '{1,0,2,2},
    '{0,0,2,2}, '{0,2,2,0},
    '{0,2,1,0}, '{0,0,1,2},
    '{1,0,2,1}, '{1,1,2,0},
    '{0,1,2,0}, '{0,0,2,1},
    '{0,0,1,1}, '{0,1,1,0}
  };

  logic  v1_q, v2_q, v3_q;
  elem_t a1_q [N_ROW][N_COL];
  elem_t a2_q [N_ROW][N_COL];
  elem_t a3_q [N_ROW][N_COL];
  prod_t prod_q [N_PROD];
  cof_t  cof_q [N_COF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q[0][0] <= data_i.a00; a1_q[0][1] <= data_i.a01;
      a1_q[0][2] <= data_i.a02; a1_q[0][3] <= data_i.a03;
      a1_q[1][0] <= data_i.a10; a1_q[1][1] <= data_i.a11;
      a1_q[1][2] <= data_i.a12; a1_q[1][3] <= data_i.a13;
      a1_q[2][0] <= data_i.a20; a1_q[2][1] <= data_i.a21;
      a1_q[2][2] <= data_i.a22; a1_q[2][3] <= data_i.a23;
      a2_q <= a1_q;
      a3_q <= a2_q;
    end
  end

  for (genvar p = 0; p < N_PROD; p++) begin : g_prod
    prod_t prod_d;
    assign prod_d = a1_q[PIDX[p][0]][PIDX[p][1]] * a1_q[PIDX[p][2]][PIDX[p][3]];
    always_ff @(posedge clk_i) begin
      if (en_i) prod_q[p] <= prod_d;
    end
  end

  for (genvar k = 0; k < N_COF; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en_i) cof_q[k] <= COF_W'(prod_q[2*k]) - COF_W'(prod_q[2*k+1]);
    end
  end

  assign valid_o = v3_q;
  assign a_o     = a3_q;
  assign cof_o   = cof_q;

endmodule

[design/ami_det.sv]
// Determinant and negated translation sums: split products, merge, three-term sums.
module ami_det (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ami_pkg::elem_t  a_i [ami_pkg::N_ROW][ami_pkg::N_COL],
  input  ami_pkg::cof_t   cof_i [ami_pkg::N_COF],
  output logic            valid_o,
  output ami_pkg::sum_t   det_o,
  output ami_pkg::sum_t   tn_o [ami_pkg::N_ROW],
  output ami_pkg::cof_t   cof_o [ami_pkg::N_COF]
);
  import ami_pkg::*;

  localparam int unsigned N_MUL = N_ROW + N_COF;

  logic  v1_q, v2_q, v3_q;
  cof_t  c1_q [N_COF];
  cof_t  c2_q [N_COF];
  cof_t  c3_q [N_COF];
  pp_t   plo_q [N_MUL];
  pp_t   phi_q [N_MUL];
  full_t full_q [N_MUL];
  sum_t  det_q;
  sum_t  tn_q [N_ROW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= cof_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
    end
  end

  // first three: a0k * c(3k) for the determinant; rest: cofactor times translation
  for (genvar n = 0; n < N_MUL; n++) begin : g_mul
    elem_t a_w;
    cof_t  c_w;
    pp_t   lo_w, hi_w;
    if (n < N_ROW) begin : g_d
      assign a_w = a_i[0][n];
      assign c_w = cof_i[3*n];
    end else begin : g_t
      assign a_w = a_i[(n-N_ROW)%3][3];
      assign c_w = cof_i[n-N_ROW];
    end
    assign lo_w = a_w * $signed({1'b0, c_w[DATA_W-1:0]});
    assign hi_w = a_w * $signed(c_w[COF_W-1:DATA_W]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[n]  <= lo_w;
        phi_q[n]  <= hi_w;
        full_q[n] <= (FULL_W'(phi_q[n]) <<< DATA_W) + FULL_W'(plo_q[n]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= SUM_W'(full_q[0]) + SUM_W'(full_q[1]) + SUM_W'(full_q[2]);
      for (int i = 0; i < N_ROW; i++) begin
        tn_q[i] <= -(SUM_W'(full_q[N_ROW+3*i]) + SUM_W'(full_q[N_ROW+3*i+1])
                     + SUM_W'(full_q[N_ROW+3*i+2]));
      end
    end
  end

  assign valid_o = v3_q;
  assign det_o   = det_q;
  assign tn_o    = tn_q;
  assign cof_o   = c3_q;

endmodule

[design/ami_div.sv]
// Twelve-lane pipelined floor divider by the determinant, with saturation.
module ami_div #(
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ami_pkg::sum_t   det_i,
  input  ami_pkg::sum_t   tn_i [ami_pkg::N_ROW],
  input  ami_pkg::cof_t   cof_i [ami_pkg::N_COF],
  output logic            valid_o,
  output ami_pkg::elem_t  res_o [ami_pkg::N_OUT]
);
  import ami_pkg::*;

  localparam int unsigned NW = MAG_W + FRAC_BITS;   // numerator magnitude
  localparam int unsigned SW = NW + 1;
  localparam int unsigned WW = NW + QB_W + 1;       // room for |D| << QB_W
  localparam int unsigned NS = QB_W + 1;            // overflow check plus one per bit
  localparam logic [QB_W:0] NEG_LIM = (QB_W+1)'(1) << (DATA_W - 1);

  // magnitude stage
  logic             vm_q;
  logic [NW-1:0]    nm_q [N_OUT];
  logic             nsm_q [N_OUT];
  logic [MAG_W-1:0] dm_q;
  logic             dsm_q, dzm_q;

  // overflow check (index 0) and one stage per quotient bit
  logic             v_q   [NS];
  logic [NW-1:0]    rem_q [NS][N_OUT];
  logic [QB_W-1:0]  quo_q [NS][N_OUT];
  logic             ovf_q [NS][N_OUT];
  logic             ns_q  [NS][N_OUT];
  logic [MAG_W-1:0] dmag_q [NS];
  logic             ds_q  [NS];
  logic             dz_q  [NS];

  logic             vf_q;
  elem_t            res_q [N_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
      v_q[0] <= vm_q;
      for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
      vf_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsm_q <= det_i[SUM_W-1];
      dm_q  <= det_i[SUM_W-1] ? MAG_W'(-det_i) : MAG_W'(det_i);
      dzm_q <= (det_i == '0);
      dmag_q[0] <= dm_q;
      ds_q[0]   <= dsm_q;
      dz_q[0]   <= dzm_q;
      for (int s = 1; s < NS; s++) begin
        dmag_q[s] <= dmag_q[s-1];
        ds_q[s]   <= ds_q[s-1];
        dz_q[s]   <= dz_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < N_OUT; l++) begin : g_lane
    localparam int unsigned ROW = l / N_COL;
    localparam int unsigned COL = l % N_COL;
    logic signed [SW-1:0] num_w;
    logic                 ovf_w;
    logic                 neg_w, rnz_w;
    logic [QB_W:0]        mneg_w;
    elem_t                res_w;

    if (COL < N_ROW) begin : g_lin
      assign num_w = SW'(cof_i[3*ROW+COL]) <<< (2 * FRAC_BITS);
    end else begin : g_tr
      assign num_w = SW'(tn_i[ROW]) <<< FRAC_BITS;
    end

    assign ovf_w = WW'(nm_q[l]) >= (WW'(dm_q) << QB_W);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nsm_q[l]    <= num_w[SW-1];
        nm_q[l]     <= num_w[SW-1] ? NW'(-num_w) : NW'(num_w);
        rem_q[0][l] <= nm_q[l];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= ovf_w;
        ns_q[0][l]  <= nsm_q[l];
      end
    end

    // restoring step: bit K of the quotient
    for (genvar s = 1; s < NS; s++) begin : g_step
      localparam int unsigned K = QB_W - s;
      logic [WW:0] diff_w;
      assign diff_w = {1'b0, WW'(rem_q[s-1][l])} - {1'b0, (WW'(dmag_q[s-1]) << K)};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l] <= diff_w[WW] ? rem_q[s-1][l] : diff_w[NW-1:0];
          quo_q[s][l] <= {quo_q[s-1][l][QB_W-2:0], ~diff_w[WW]};
          ovf_q[s][l] <= ovf_q[s-1][l];
          ns_q[s][l]  <= ns_q[s-1][l];
        end
      end
    end

    assign neg_w  = ns_q[NS-1][l] ^ ds_q[NS-1];
    assign rnz_w  = |rem_q[NS-1][l];
    // a negative quotient rounds away from zero when anything remains
    assign mneg_w = {1'b0, quo_q[NS-1][l]} + (QB_W+1)'(rnz_w);

    always_comb begin
      priority if (dz_q[NS-1]) begin
        res_w = '0;
      end else if (ovf_q[NS-1][l]) begin
        res_w = neg_w ? ELEM_MIN : ELEM_MAX;
      end else if (!neg_w) begin
        res_w = (|quo_q[NS-1][l][QB_W-1:DATA_W-1]) ? ELEM_MAX
                                                   : elem_t'(quo_q[NS-1][l][DATA_W-1:0]);
      end else begin
        res_w = (mneg_w > NEG_LIM) ? ELEM_MIN : elem_t'(DATA_W'(-mneg_w));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) res_q[l] <= res_w;
    end
  end

  assign valid_o = vf_q;
  assign res_o   = res_q;

endmodule

[design/affine_matrix_inverse_top.sv]
// Top level of the pipelined affine 4x4 matrix inverse.
// Takes the upper three rows of an affine matrix (bottom row 0,0,0,1) in signed
// fixed point with FRAC_BITS fraction bits and returns the upper three rows of
// its inverse, each element floored and saturated to 32 bits; a singular matrix
// gives all zeros. One matrix is accepted every cycle unless the output stalls.
// Six stages form the cofactors and the determinant, two take magnitudes and
// check for overflow, 33 stages of a restoring divider (one quotient bit each)
// run per output element, and one stage saturates into the output register.
// When the output register is held the whole pipeline stalls, so in_i.ready
// follows out_o.ready while a result waits.
module affine_matrix_inverse_top #(
  parameter int unsigned FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ami_in_if.sink    in_i,
  ami_out_if.source out_o
);
  import ami_pkg::*;

  logic  en;
  logic  cof_v, det_v, div_v;
  elem_t a_w [N_ROW][N_COL];
  cof_t  cof_w [N_COF];
  cof_t  cofd_w [N_COF];
  sum_t  det_w;
  sum_t  tn_w [N_ROW];
  elem_t res_w [N_OUT];

  assign en         = !div_v || out_o.ready;
  assign in_i.ready = en;

  ami_cof u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (cof_v),
    .a_o     (a_w),
    .cof_o   (cof_w)
  );

  ami_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_v),
    .a_i     (a_w),
    .cof_i   (cof_w),
    .valid_o (det_v),
    .det_o   (det_w),
    .tn_o    (tn_w),
    .cof_o   (cofd_w)
  );

  ami_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_v),
    .det_i   (det_w),
    .tn_i    (tn_w),
    .cof_i   (cofd_w),
    .valid_o (div_v),
    .res_o   (res_w)
  );

  assign out_o.valid    = div_v;
  assign out_o.data.r00 = res_w[0];
  assign out_o.data.r01 = res_w[1];
  assign out_o.data.r02 = res_w[2];
  assign out_o.data.r03 = res_w[3];
  assign out_o.data.r10 = res_w[4];
  assign out_o.data.r11 = res_w[5];
  assign out_o.data.r12 = res_w[6];
  assign out_o.data.r13 = res_w[7];
  assign out_o.data.r20 = res_w[8];
  assign out_o.data.r21 = res_w[9];
  assign out_o.data.r22 = res_w[10];
  assign out_o.data.r23 = res_w[11];

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_cof_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(cof_v))
    else $error("cofactor stage valid moved during stall");

  a_det_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(det_v))
    else $error("determinant stage valid moved during stall");
`endif

endmodule

[test/affine_matrix_inverse_top_test.sv]
// Testbench for the affine matrix inverse: directed and random matrices checked against a predictor.
module affine_matrix_inverse_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ami_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  ami_in_if  in_ch ();
  ami_out_if out_ch ();

  affine_matrix_inverse_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  out_t inverse_q[$];

  // Floored quotient of wide signed values, saturated to 32 bits.
  function automatic elem_t floor_sat(logic signed [255:0] n, logic signed [255:0] d);
    logic signed [255:0] q;
    logic signed [255:0] r;
    q = n / d;
    r = n - q * d;
    if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
    if (q > 256'sd2147483647) return ELEM_MAX;
    if (q < -256'sd2147483648) return ELEM_MIN;
    return elem_t'(q[31:0]);
  endfunction

  function automatic out_t invert_affine(in_t m);
    logic signed [255:0] a[3][4];
    logic signed [255:0] c[3][3];
    logic signed [255:0] det;
    logic signed [255:0] t;
    elem_t res[3][4];
    out_t o;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02; a[0][3] = m.a03;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12; a[1][3] = m.a13;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22; a[2][3] = m.a23;
    // adjugate: c[i][j] is element (i,j) of the inverse numerator
    c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    c[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    c[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    c[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    c[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    c[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    c[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    det = a[0][0]*c[0][0] + a[0][1]*c[1][0] + a[0][2]*c[2][0];
    for (int i = 0; i < 3; i++) begin
      t = -(c[i][0]*a[0][3] + c[i][1]*a[1][3] + c[i][2]*a[2][3]);
      for (int j = 0; j < 3; j++)
        res[i][j] = (det == 0) ? '0 : floor_sat(c[i][j] <<< 32, det);
      res[i][3] = (det == 0) ? '0 : floor_sat(t <<< 16, det);
    end
    o = '{res[0][0], res[0][1], res[0][2], res[0][3],
          res[1][0], res[1][1], res[1][2], res[1][3],
          res[2][0], res[2][1], res[2][2], res[2][3]};
    return o;
  endfunction

  // valid stays high after a transaction so that the next one can follow at once
  task automatic send_matrix(in_t m);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    inverse_q.push_back(invert_affine(m));
    @(negedge clk_i);
  endtask

  // Receiver: random back-pressure, driven on the falling edge.
  always @(negedge clk_i) begin
    out_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (inverse_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_ch.data);
      end else begin
        exp_r = inverse_q.pop_front();
        for (int k = 0; k < N_OUT; k++) begin
          if (exp_r[k*32 +: 32] !== out_ch.data[k*32 +: 32]) begin
            errors++;
            if (errors <= 10)
              $display("field %0d: expected %h, got %h", N_OUT-1-k,
                       exp_r[k*32 +: 32], out_ch.data[k*32 +: 32]);
          end
        end
      end
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(5))
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(8)) - 4) <<< 16;
      2: return ($urandom_range(1) ? ELEM_MAX : ELEM_MIN);
      3: return elem_t'($signed($urandom_range(2000)) - 1000);
      default: return elem_t'($signed($urandom_range(32'h80000)) - 32'sh40000);
    endcase
  endfunction

  function automatic in_t rand_matrix();
    in_t m;
    m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // sometimes make it singular by copying a row's linear part
    if ($urandom_range(15) == 0) {m.a20, m.a21, m.a22} = {m.a00, m.a01, m.a02};
    return m;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    elem_t one = 32'sh10000;
    send_matrix('{one, 0, 0, 0, 0, one, 0, 0, 0, 0, one, 0});
    send_matrix('{one, 0, 0, 32'sh30000, 0, one, 0, -32'sh20000, 0, 0, one, ELEM_MAX});
    send_matrix('{32'sh20000, 0, 0, 1, 0, 32'sh8000, 0, 2, 0, 0, -32'sh40000, 3});
    send_matrix('0);                                          // singular
    send_matrix('{one, one, one, 5, one, one, one, 6, 0, 0, one, 7});
    send_matrix('{1, 0, 0, ELEM_MAX, 0, 1, 0, ELEM_MIN, 0, 0, 1, 0}); // saturating
    send_matrix('{ELEM_MAX, 0, 0, 0, 0, ELEM_MAX, 0, 0, 0, 0, ELEM_MAX, 0});
    send_matrix('{ELEM_MIN, 0, 0, ELEM_MIN, 0, ELEM_MIN, 0, ELEM_MAX, 0, 0, ELEM_MIN, -1});
    send_matrix('{ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MAX,
                  ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MAX});
    send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
    send_matrix('{3, 0, 0, 1, 0, 3, 0, 1, 0, 0, 3, 1});       // inexact division
    send_matrix('{0, one, 0, 9, one, 0, 0, -9, 0, 0, -one, 4});
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_matrix(rand_matrix());
  endtask

  task automatic test_drain_pause();
    idle_pct = 0;
    stall_pct = 30;
    for (int i = 0; i < 20; i++) send_matrix(rand_matrix());
    wait_drained();
    for (int i = 0; i < 20; i++) send_matrix(rand_matrix());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(500, 0, 0);
    test_random(400, 74, 0);
    test_random(400, 0, 74);
    test_random(400, 9, 9);
    test_drain_pause();
    stall_pct = 0;
    wait_drained();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
